### design/adcseq_pkg.sv
`default_nettype none
package adcseq_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic       CFG_SAMPLE_OFFSET = 1'b0;
  localparam logic       CFG_ERROR_LIMIT   = 1'b1;
  localparam logic [7:0] ERROR_LIMIT_RESET = 8'd10;
  localparam logic [7:0] COUNT_MAX         = 8'hFF;
  localparam logic [3:0] STATUS_GOOD       = 4'hB;
  localparam int         STATUS_BUSY_BIT   = 7;
  localparam logic [15:0] MIDSCALE         = 16'h8000;

  typedef enum logic [2:0] {
    KIND_RESET,
    KIND_FILTER,
    KIND_MODE,
    KIND_POLL,
    KIND_READ,
    KIND_SAMPLE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] sample;
  } job_t;

  // number of results a job produces
  function automatic logic [2:0] seq_len(input kind_t k);
    logic [2:0] n;
    case (k)
      KIND_RESET:  n = 3'd5;
      KIND_FILTER: n = 3'd4;
      KIND_MODE:   n = 3'd3;
      KIND_POLL:   n = 3'd2;
      KIND_READ:   n = 3'd3;
      KIND_SAMPLE: n = 3'd1;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(input kind_t k, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (k)
      KIND_RESET:  b = 8'hFF;
      KIND_FILTER: begin
        case (idx)
          3'd0:    b = 8'h03;
          3'd1:    b = 8'h80;
          3'd2:    b = 8'h02;
          default: b = 8'h00;
        endcase
      end
      KIND_MODE: begin
        case (idx)
          3'd0:    b = 8'h02;
          3'd1:    b = 8'h20;
          default: b = 8'h80;
        endcase
      end
      KIND_POLL: begin
        case (idx)
          3'd0:    b = 8'h10;
          default: b = 8'h00;
        endcase
      end
      KIND_READ: begin
        case (idx)
          3'd0:    b = 8'h11;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### design/bridge_adc_spi_poll_sequencer_core.sv
// with an empty queue and an idle serializer, an accepted item that makes results
// goes into the job queue, then into the serializer, which shows its first result
// an item that makes n results (1 to 5) holds the serializer until its last result
// is taken, one result per cycle while result_ready is high; other items queue nothing
// a four-entry job queue lets items be taken while results wait to be delivered
// reset (synchronous, rst high): phase to reset, error count 0, offset 0, limit 10,
// queue and serializer empty
`default_nettype none
module bridge_adc_spi_poll_sequencer_core
  import adcseq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         item_valid,
  output logic              item_ready,
  input  wire logic         opcode,
  input  wire logic [7:0]   rx_first_byte,
  input  wire logic [7:0]   rx_second_byte,
  output logic              result_valid,
  input  wire logic         result_ready,
  output logic              tx_valid,
  output logic [7:0]        tx_byte,
  output logic              last,
  output logic [2:0]        rx_expected,
  output logic              sample_valid,
  output logic signed [15:0] sample
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  adcseq_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .opcode         (opcode),
    .rx_first_byte  (rx_first_byte),
    .rx_second_byte (rx_second_byte),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  adcseq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  adcseq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .last         (last),
    .rx_expected  (rx_expected),
    .sample_valid (sample_valid),
    .sample       (sample)
  );

endmodule
`default_nettype wire

### design/adcseq_front.sv
`default_nettype none
module adcseq_front
  import adcseq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        opcode,
  input  wire logic [7:0]  rx_first_byte,
  input  wire logic [7:0]  rx_second_byte,
  input  wire logic        q_full,
  output logic             push,
  output job_t             push_job
);

  typedef enum logic [4:0] {
    PH_RESET  = 5'b00001,
    PH_FILTER = 5'b00010,
    PH_MODE   = 5'b00100,
    PH_POLL   = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  bad_count, bad_count_next;
  logic [15:0] sample_offset;
  logic [7:0]  error_limit;
  logic [7:0]  count_inc;
  logic [15:0] raw;
  logic [15:0] sample_calc;
  logic        accept;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  assign raw         = {rx_first_byte, rx_second_byte};
  assign sample_calc = (raw == 16'd0) ? 16'd0 : raw + MIDSCALE + sample_offset;
  assign count_inc   = (bad_count == COUNT_MAX) ? COUNT_MAX : bad_count + 8'd1;

  always_comb begin
    phase_next      = phase;
    bad_count_next  = bad_count;
    push            = 1'b0;
    push_job.kind   = KIND_RESET;
    push_job.sample = sample_calc;
    if (accept) begin
      if (!opcode) begin
        case (phase)
          PH_RESET: begin
            phase_next    = PH_FILTER;
            push          = 1'b1;
            push_job.kind = KIND_RESET;
          end
          PH_FILTER: begin
            phase_next    = PH_MODE;
            push          = 1'b1;
            push_job.kind = KIND_FILTER;
          end
          PH_MODE: begin
            phase_next    = PH_POLL;
            push          = 1'b1;
            push_job.kind = KIND_MODE;
          end
          PH_POLL: begin
            push          = 1'b1;
            push_job.kind = KIND_POLL;
          end
          default: phase_next = PH_RESET;
        endcase
      end else begin
        case (phase)
          PH_POLL: begin
            if (rx_first_byte[3:0] != STATUS_GOOD) begin
              bad_count_next = count_inc;
              if (count_inc > error_limit) begin
                phase_next     = PH_RESET;
                bad_count_next = 8'd0;
              end
            end else if (!rx_first_byte[STATUS_BUSY_BIT]) begin
              bad_count_next = 8'd0;
              phase_next     = PH_DATA;
              push           = 1'b1;
              push_job.kind  = KIND_READ;
            end
          end
          PH_DATA: begin
            phase_next    = PH_POLL;
            push          = 1'b1;
            push_job.kind = KIND_SAMPLE;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RESET;
      bad_count     <= 8'd0;
      sample_offset <= 16'd0;
      error_limit   <= ERROR_LIMIT_RESET;
    end else begin
      phase     <= phase_next;
      bad_count <= bad_count_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_OFFSET: sample_offset <= cfg_data;
          CFG_ERROR_LIMIT:   error_limit   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // a bad status never leaves the count above the limit
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_POLL) && !$past(cfg_we) && !$past(rst) && $past(phase == PH_POLL)
      |-> (bad_count <= error_limit) || (bad_count == $past(bad_count)))
    else $error("bad status count passed the limit without restart");

  // a request in the data phase drops back to reset and queues nothing
  assert property (@(posedge clk) disable iff (rst)
    accept && !opcode && (phase == PH_DATA) |-> !push)
    else $error("request in data phase queued a job");

endmodule
`default_nettype wire

### design/adcseq_queue.sv
`default_nettype none
module adcseq_queue
  import adcseq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      q_full,
  input  wire logic pop,
  output logic      q_valid,
  output job_t      q_job
);

  job_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;

  assign q_full  = (count == QCW'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= QCW'(QDEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && !q_valid))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

### design/adcseq_back.sv
`default_nettype none
module adcseq_back
  import adcseq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  job_t              q_job,
  output logic              pop,
  output logic              result_valid,
  input  wire logic         result_ready,
  output logic              tx_valid,
  output logic [7:0]        tx_byte,
  output logic              last,
  output logic [2:0]        rx_expected,
  output logic              sample_valid,
  output logic signed [15:0] sample
);

  logic       busy;
  job_t       job;
  logic [2:0] idx;
  logic [2:0] len;
  logic       is_sample;
  logic       done;

  assign len       = seq_len(job.kind);
  assign is_sample = (job.kind == KIND_SAMPLE);
  assign done      = result_valid && result_ready && last;

  assign result_valid = busy;
  assign tx_valid     = !is_sample;
  assign tx_byte      = is_sample ? 8'h00 : seq_byte(job.kind, idx);
  assign last         = (idx == len - 3'd1);
  assign rx_expected  = is_sample ? 3'd0 : len;
  assign sample_valid = is_sample;
  assign sample       = is_sample ? job.sample : 16'sd0;

  // take the next request as soon as the current one is finished
  assign pop = q_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (result_valid && result_ready) begin
      idx <= idx + 3'd1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> (idx < len))
    else $error("result index past sequence length");

  assert property (@(posedge clk) disable iff (rst)
    busy && !result_ready |=> busy && $stable(idx))
    else $error("stalled result advanced");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last |=> busy && (idx == $past(idx) + 3'd1))
    else $error("sequence skipped or repeated a byte");

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb;
  import adcseq_pkg::*;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RECEIVE = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   SETTLE_CYCLES = 12;

  typedef enum logic [2:0] {
    PH_RESET,
    PH_FILTER,
    PH_MODE,
    PH_POLL,
    PH_DATA
  } phase_t;

  typedef struct {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  rx_expected;
    logic        sample_valid;
    logic [15:0] sample;
  } adc_result_t;

  class adc_seq_scoreboard;
    phase_t      phase;
    logic [7:0]  bad_count;
    logic [7:0]  error_limit;
    logic [15:0] offset;
    adc_result_t expected_q[$];
    int          errors;
    int          n_requests;
    int          n_results;
    int          n_samples;

    function new();
      phase       = PH_RESET;
      bad_count   = 8'd0;
      error_limit = ERROR_LIMIT_RESET;
      offset      = 16'd0;
      errors      = 0;
      n_requests  = 0;
      n_results   = 0;
      n_samples   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // bytes packed first byte in the top lane
    function void push_bytes(int n, logic [39:0] bytes);
      adc_result_t r;
      for (int k = 0; k < n; k++) begin
        r.tx_valid     = 1'b1;
        r.tx_byte      = bytes[39 - 8 * k -: 8];
        r.last         = (k == n - 1);
        r.rx_expected  = 3'(n);
        r.sample_valid = 1'b0;
        r.sample       = 16'd0;
        expected_q.push_back(r);
      end
    endfunction

    function void note_request(logic op, logic [7:0] b1, logic [7:0] b2);
      adc_result_t r;
      logic [15:0] raw;
      n_requests++;
      if (op == OP_REQUEST) begin
        case (phase)
          PH_RESET: begin
            push_bytes(5, 40'hFF_FF_FF_FF_FF);
            phase = PH_FILTER;
          end
          PH_FILTER: begin
            push_bytes(4, 40'h03_80_02_00_00);
            phase = PH_MODE;
          end
          PH_MODE: begin
            push_bytes(3, 40'h02_20_80_00_00);
            phase = PH_POLL;
          end
          PH_POLL: push_bytes(2, 40'h10_00_00_00_00);
          default: phase = PH_RESET;
        endcase
      end else if (phase == PH_POLL) begin
        if (b1[3:0] != STATUS_GOOD) begin
          if (bad_count != COUNT_MAX) bad_count++;
          if (bad_count > error_limit) begin
            phase     = PH_RESET;
            bad_count = 8'd0;
          end
        end else if (!b1[STATUS_BUSY_BIT]) begin
          bad_count = 8'd0;
          phase     = PH_DATA;
          push_bytes(3, 40'h11_00_00_00_00);
        end
      end else if (phase == PH_DATA) begin
        raw            = {b1, b2};
        r.tx_valid     = 1'b0;
        r.tx_byte      = 8'd0;
        r.last         = 1'b1;
        r.rx_expected  = 3'd0;
        r.sample_valid = 1'b1;
        r.sample       = (raw == 16'd0) ? 16'd0 : raw - MIDSCALE + offset;
        expected_q.push_back(r);
        n_samples++;
        phase = PH_POLL;
      end
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(adc_result_t got);
      adc_result_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: tx_byte %0h sample %0h", got.tx_byte,
               got.sample);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("tx_valid", 16'(e.tx_valid), 16'(got.tx_valid));
      cmp("tx_byte", 16'(e.tx_byte), 16'(got.tx_byte));
      cmp("last", 16'(e.last), 16'(got.last));
      cmp("rx_expected", 16'(e.rx_expected), 16'(got.rx_expected));
      cmp("sample_valid", 16'(e.sample_valid), 16'(got.sample_valid));
      cmp("sample", e.sample, got.sample);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        item_valid = 1'b0;
  logic        opcode = 1'b0;
  logic [7:0]  rx_first_byte = 8'd0;
  logic [7:0]  rx_second_byte = 8'd0;
  logic        result_ready = 1'b0;
  logic        item_ready;
  logic        result_valid;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  rx_expected;
  logic        sample_valid;
  logic signed [15:0] sample;

  int rx_idle_pct = 0;
  int cycle_count = 0;
  adc_seq_scoreboard sb;

  bridge_adc_spi_poll_sequencer_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .opcode         (opcode),
    .rx_first_byte  (rx_first_byte),
    .rx_second_byte (rx_second_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .last           (last),
    .rx_expected    (rx_expected),
    .sample_valid   (sample_valid),
    .sample         (sample)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result('{tx_valid, tx_byte, last, rx_expected, sample_valid, sample});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending());
      $display("tb: done, errors");
      $finish;
    end
  end

  // valid stays up between back-to-back requests; only an idle cycle lowers it
  task automatic send_item(input logic op, input logic [7:0] b1, input logic [7:0] b2,
                           input int tx_pct);
    while ($urandom_range(99) < tx_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid     <= 1'b1;
    opcode         <= op;
    rx_first_byte  <= b1;
    rx_second_byte <= b2;
    do @(posedge clk); while (!item_ready);
    sb.note_request(op, b1, b2);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] offset, input logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_OFFSET;
    cfg_data  <= offset;
    @(posedge clk);
    cfg_index <= CFG_ERROR_LIMIT;
    cfg_data  <= {8'h00, limit};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.offset      = offset;
    sb.error_limit = limit;
  endtask

  function automatic logic [7:0] bad_status();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b[3:0] == STATUS_GOOD) b[0] = 1'b0;
    return b;
  endfunction

  // mostly well-formed poll/read cycles, with busy, bad status and stray requests
  task automatic run_random(input int n, input int tx_pct, input int rx_pct, input bit pause);
    int         done_n;
    int         pick;
    logic       op;
    logic [7:0] b1;
    logic [7:0] b2;
    bit         ignored;
    rx_idle_pct = rx_pct;
    done_n = 0;
    while (done_n < n) begin
      pick = $urandom_range(99);
      b1 = 8'($urandom_range(255));
      b2 = 8'($urandom_range(255));
      case (sb.phase)
        PH_POLL: begin
          if (pick < 25) begin
            op = OP_REQUEST;
          end else begin
            op = OP_RECEIVE;
            if (pick < 65) b1 = {1'b0, b1[6:4], STATUS_GOOD};
            else if (pick < 75) b1 = {1'b1, b1[6:4], STATUS_GOOD};
            else b1 = bad_status();
          end
        end
        PH_DATA: begin
          if (pick < 8) begin
            op = OP_REQUEST;
          end else begin
            op = OP_RECEIVE;
            if (pick < 16) {b1, b2} = 16'h0000;
            else if (pick < 24) {b1, b2} = 16'hFFFF;
          end
        end
        default: op = (pick < 88) ? OP_REQUEST : OP_RECEIVE;
      endcase
      ignored = (op == OP_RECEIVE) && (sb.phase != PH_POLL) && (sb.phase != PH_DATA);
      send_item(op, b1, b2, tx_pct);
      if (!ignored) done_n++;
      if (pause && $urandom_range(39) == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // start-up sequence at reset settings, receives in set-up phases are dropped
    send_item(OP_RECEIVE, 8'hFF, 8'hFF, 0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);
    send_item(OP_RECEIVE, 8'h0B, 8'h00, 0);
    send_item(OP_REQUEST, 8'hFF, 8'hFF, 0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);
    send_item(OP_RECEIVE, 8'h0B, 8'hFF, 0);
    send_item(OP_RECEIVE, 8'h00, 8'h00, 0);   // raw zero gives zero
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);
    send_item(OP_RECEIVE, 8'h8B, 8'h00, 0);   // busy
    send_item(OP_RECEIVE, 8'h7B, 8'h00, 0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);   // request in data phase restarts
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 0);
    send_item(OP_RECEIVE, 8'h0B, 8'h00, 0);
    send_item(OP_RECEIVE, 8'hFF, 8'hFF, 0);
    send_item(OP_RECEIVE, 8'h0B, 8'h00, 0);
    send_item(OP_RECEIVE, 8'h80, 8'h00, 0);
    send_item(OP_RECEIVE, 8'h3B, 8'h00, 0);
    send_item(OP_RECEIVE, 8'h00, 8'h01, 0);
    send_item(OP_RECEIVE, 8'hFF, 8'h00, 0);   // bad status
    send_item(OP_RECEIVE, 8'hFA, 8'h00, 0);
    settle();

    set_config(16'h8000, 8'd0);
    run_random(80, 35, 67, 1'b1);
    settle();

    set_config(16'h7FFF, COUNT_MAX);
    run_random(80, 67, 35, 1'b1);
    settle();

    set_config(16'($urandom_range(65535)), 8'($urandom_range(1, 6)));
    run_random(80, 0, 0, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("tb: %0d requests, %0d results checked, %0d samples", sb.n_requests,
             sb.n_results, sb.n_samples);
    $display("tb: offsets at both ends and random, error limits 0, 255 and small random");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
